@@ hw/rtl/spq_pkg.sv @@
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types, codes and helpers of the stable priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

  // default number of heap entries
  localparam int unsigned Capacity = 64;

  // fixed field widths
  localparam int unsigned TagW    = 16;
  localparam int unsigned SevW    = 16;
  localparam int unsigned StampW  = 32;
  localparam int unsigned StatusW = 3;
  localparam int unsigned OccW    = 7;
  localparam int unsigned ActionW = 2;

  // action codes (any other code clears)
  localparam logic [ActionW-1:0] ACT_INSERT = 2'd0;
  localparam logic [ActionW-1:0] ACT_SERVE  = 2'd1;
  localparam logic [ActionW-1:0] ACT_CLEAR  = 2'd2;

  // status codes
  localparam logic [StatusW-1:0] ST_INSERTED = 3'd0;
  localparam logic [StatusW-1:0] ST_SERVED   = 3'd1;
  localparam logic [StatusW-1:0] ST_EMPTY    = 3'd2;
  localparam logic [StatusW-1:0] ST_DROPPED  = 3'd3;
  localparam logic [StatusW-1:0] ST_CLEARED  = 3'd4;

  // one heap entry: severity, arrival stamp, tag
  typedef struct packed {
    logic [SevW-1:0]   sev;
    logic [StampW-1:0] stamp;
    logic [TagW-1:0]   tag;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // a goes out before b: higher severity, then earlier stamp
  function automatic logic ahead(entry_t a, entry_t b);
    logic res;
    if (a.sev != b.sev) begin
      res = ($signed(a.sev) > $signed(b.sev));
    end else begin
      res = (a.stamp < b.stamp);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/spq_ram.sv @@
// ----------------------------------------------------------------------------
// spq_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(Depth)-1:0] wr_addr_i,
  input  wire logic [Width-1:0]         wr_data_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(Depth)-1:0] rd_addr_i,
  output      logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/stable_priority_queue_unit.sv @@
// ----------------------------------------------------------------------------
// stable_priority_queue_unit
// Stable priority queue held as a binary max-heap in one synchronous RAM.
//
// Input channel (in_valid_i/in_ready_o) carries action, tag and severity;
// every transfer yields exactly one result transfer on the output channel
// (out_valid_o/out_ready_i) with status, served tag and occupancy.
// One item is processed at a time; in_ready_o is high whenever the engine
// is idle, also while the previous result still waits in the output register.
// The result register is loaded as the engine returns to idle.
// Insert: sift-up, each heap level a parent read then a compare and write.
// Serve: root and last entry read, then sift-down, each level a left read,
// a right read, then a compare and write.
// Clear, empty serve and dropped insert go straight to the done state.
// The single RAM read port is why these reads follow one another.
// Reset empties the queue and zeroes the arrival counter; RAM contents are
// left as they are, since only entries below the count are ever read.
// A stalled receiver holds the result; a finished item then waits in its
// final state until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_priority_queue_unit #(
  parameter int unsigned CAPACITY = spq_pkg::Capacity
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output      logic                          in_ready_o,
  input  wire logic [spq_pkg::ActionW-1:0]   action_i,
  input  wire logic [spq_pkg::TagW-1:0]      patient_tag_i,
  input  wire logic signed [spq_pkg::SevW-1:0] severity_i,
  output      logic                          out_valid_o,
  input  wire logic                          out_ready_i,
  output      logic [spq_pkg::StatusW-1:0]   status_o,
  output      logic [spq_pkg::TagW-1:0]      served_tag_o,
  output      logic [spq_pkg::OccW-1:0]      occupancy_o
);

  localparam int unsigned AW    = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned IW    = CNT_W + 1;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_UP_RD   = 9'b000000010,
    S_UP_CMP  = 9'b000000100,
    S_SV_ROOT = 9'b000001000,
    S_SV_LAST = 9'b000010000,
    S_DN_RDL  = 9'b000100000,
    S_DN_RDR  = 9'b001000000,
    S_DN_CMP  = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_e;

  state_e                          state_q, state_d;
  logic [CNT_W-1:0]                count_q, count_d;
  logic [spq_pkg::StampW-1:0]      arr_q, arr_d;
  logic [CNT_W-1:0]                idx_q, idx_d;
  spq_pkg::entry_t                 cur_q, cur_d;
  spq_pkg::entry_t                 left_q, left_d;
  logic                            r_ok_q, r_ok_d;
  logic [spq_pkg::StatusW-1:0]     res_status_q, res_status_d;
  logic [spq_pkg::TagW-1:0]        res_tag_q, res_tag_d;
  logic                            out_valid_q, out_valid_d;
  logic [spq_pkg::StatusW-1:0]     out_status_q, out_status_d;
  logic [spq_pkg::TagW-1:0]        out_tag_q, out_tag_d;
  logic [spq_pkg::OccW-1:0]        out_occ_q, out_occ_d;

  // ram port signals
  logic                            wr_en;
  logic [AW-1:0]                   wr_addr;
  spq_pkg::entry_t                 wr_data;
  logic                            rd_en;
  logic [AW-1:0]                   rd_addr;
  logic [spq_pkg::EntryW-1:0]      rd_data;
  spq_pkg::entry_t                 rd_ent;

  // heap index arithmetic
  logic [CNT_W-1:0]                parent_idx;
  logic [IW-1:0]                   left_idx;
  logic [IW-1:0]                   right_idx;
  logic [IW-1:0]                   count_ext;
  logic                            take_l;
  logic                            take_r;
  spq_pkg::entry_t                 best_lc;
  logic [CNT_W+spq_pkg::OccW-1:0]  occ_ext;

  assign rd_ent     = spq_pkg::entry_t'(rd_data);
  assign parent_idx = (idx_q - CNT_W'(1)) >> 1;
  assign left_idx   = {idx_q, 1'b0} + IW'(1);
  assign right_idx  = {idx_q, 1'b0} + IW'(2);
  assign count_ext  = {1'b0, count_q};
  assign occ_ext    = {{spq_pkg::OccW{1'b0}}, count_q};

  // sift-down choice between hole entry, left child and right child
  assign take_l  = spq_pkg::ahead(left_q, cur_q);
  assign best_lc = take_l ? left_q : cur_q;
  assign take_r  = r_ok_q && spq_pkg::ahead(rd_ent, best_lc);

  spq_ram #(
    .Width (spq_pkg::EntryW),
    .Depth (CAPACITY)
  ) u_heap_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign served_tag_o = out_tag_q;
  assign occupancy_o  = out_occ_q;

  // main sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    arr_d        = arr_q;
    idx_d        = idx_q;
    cur_d        = cur_q;
    left_d       = left_q;
    r_ok_d       = r_ok_q;
    res_status_d = res_status_q;
    res_tag_d    = res_tag_q;
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_tag_d    = out_tag_q;
    out_occ_d    = out_occ_q;
    wr_en        = 1'b0;
    wr_addr      = idx_q[AW-1:0];
    wr_data      = cur_q;
    rd_en        = 1'b0;
    rd_addr      = '0;

    // result leaves on output transfer
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_tag_d = '0;
          if (action_i == spq_pkg::ACT_INSERT) begin
            arr_d = arr_q + spq_pkg::StampW'(1);
            if (count_q == CNT_W'(CAPACITY)) begin
              res_status_d = spq_pkg::ST_DROPPED;
              state_d      = S_DONE;
            end else begin
              cur_d.sev    = severity_i;
              cur_d.stamp  = arr_q;
              cur_d.tag    = patient_tag_i;
              idx_d        = count_q;
              count_d      = count_q + CNT_W'(1);
              res_status_d = spq_pkg::ST_INSERTED;
              state_d      = S_UP_RD;
            end
          end else if (action_i == spq_pkg::ACT_SERVE) begin
            arr_d = arr_q + spq_pkg::StampW'(1);
            if (count_q == '0) begin
              res_status_d = spq_pkg::ST_EMPTY;
              state_d      = S_DONE;
            end else begin
              rd_en        = 1'b1;
              rd_addr      = '0;
              count_d      = count_q - CNT_W'(1);
              res_status_d = spq_pkg::ST_SERVED;
              state_d      = S_SV_ROOT;
            end
          end else begin
            // clear and the unused code
            count_d      = '0;
            arr_d        = '0;
            res_status_d = spq_pkg::ST_CLEARED;
            state_d      = S_DONE;
          end
        end
      end

      // sift-up: fetch parent of the hole, or settle at the root
      S_UP_RD: begin
        if (idx_q == '0) begin
          wr_en   = 1'b1;
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = parent_idx[AW-1:0];
          state_d = S_UP_CMP;
        end
      end

      // sift-up: move parent down or settle new entry
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (spq_pkg::ahead(cur_q, rd_ent)) begin
          wr_data = rd_ent;
          idx_d   = parent_idx;
          state_d = S_UP_RD;
        end else begin
          state_d = S_DONE;
        end
      end

      // root arrives, fetch last entry unless the queue is now empty
      S_SV_ROOT: begin
        res_tag_d = rd_ent.tag;
        if (count_q == '0) begin
          state_d = S_DONE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = count_q[AW-1:0];
          state_d = S_SV_LAST;
        end
      end

      // last entry becomes the hole entry at the root
      S_SV_LAST: begin
        cur_d   = rd_ent;
        idx_d   = '0;
        state_d = S_DN_RDL;
      end

      // sift-down: fetch left child or settle
      S_DN_RDL: begin
        if (left_idx < count_ext) begin
          rd_en   = 1'b1;
          rd_addr = left_idx[AW-1:0];
          state_d = S_DN_RDR;
        end else begin
          wr_en   = 1'b1;
          state_d = S_DONE;
        end
      end

      // sift-down: keep left child, fetch right child if present
      S_DN_RDR: begin
        left_d = rd_ent;
        if (right_idx < count_ext) begin
          rd_en   = 1'b1;
          rd_addr = right_idx[AW-1:0];
          r_ok_d  = 1'b1;
        end else begin
          r_ok_d  = 1'b0;
        end
        state_d = S_DN_CMP;
      end

      // sift-down: move best child up or settle
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (take_r) begin
          wr_data = rd_ent;
          idx_d   = right_idx[CNT_W-1:0];
          state_d = S_DN_RDL;
        end else if (take_l) begin
          wr_data = left_q;
          idx_d   = left_idx[CNT_W-1:0];
          state_d = S_DN_RDL;
        end else begin
          state_d = S_DONE;
        end
      end

      // hand result to the output register
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_tag_d    = res_tag_q;
          out_occ_d    = occ_ext[spq_pkg::OccW-1:0];
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      arr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      arr_q       <= arr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    cur_q        <= cur_d;
    left_q       <= left_d;
    r_ok_q       <= r_ok_d;
    res_status_q <= res_status_d;
    res_tag_q    <= res_tag_d;
    out_status_q <= out_status_d;
    out_tag_q    <= out_tag_d;
    out_occ_q    <= out_occ_d;
  end

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks stable_priority_queue_unit against a heap model kept in a small
// class. A directed opener covers the field extremes, empty serves, severity
// ties and both clear codes. Random phases then mix, fill, drain and tie-heavy
// traffic under random sender gaps and receiver stalls, and compare every
// result transfer with the modeled status, served tag and occupancy.
// ----------------------------------------------------------------------------

module testbench;

  // spare action code, the block treats it as a clear
  localparam logic [spq_pkg::ActionW-1:0] ACT_SPARE = 2'd3;

  localparam int unsigned PHASES       = 15;
  localparam int unsigned PHASE_ITEMS  = 102;
  localparam int unsigned SETTLE_TICKS = 40;
  localparam int unsigned TIMEOUT_NS   = 10_000_000;

  typedef enum int unsigned {MIX_PHASE, FILL_PHASE, DRAIN_PHASE, TIE_PHASE} mix_e;

  // one predicted result transfer
  typedef struct packed {
    logic [spq_pkg::StatusW-1:0] status;
    logic [spq_pkg::TagW-1:0]    tag;
    logic [spq_pkg::OccW-1:0]    occ;
  } reply_t;

  // heap model of the queue plus the list of results still to come
  class heap_predictor;
    spq_pkg::entry_t            heap_mem[spq_pkg::Capacity];
    int unsigned                held;
    logic [spq_pkg::StampW-1:0] arrival;
    reply_t                     expected_replies[$];
    int unsigned                mismatches;
    int unsigned                requests_taken;
    int unsigned                status_count[5];
    int unsigned                peak_held;

    function new();
      held           = 0;
      arrival        = '0;
      mismatches     = 0;
      requests_taken = 0;
      peak_held      = 0;
      foreach (status_count[i]) status_count[i] = 0;
    endfunction

    // higher severity first, earlier stamp breaks a tie
    function bit outranks(spq_pkg::entry_t a, spq_pkg::entry_t b);
      if (a.sev != b.sev) begin
        return $signed(a.sev) > $signed(b.sev);
      end
      return a.stamp < b.stamp;
    endfunction

    function void swap(int unsigned i, int unsigned j);
      spq_pkg::entry_t tmp;
      tmp         = heap_mem[i];
      heap_mem[i] = heap_mem[j];
      heap_mem[j] = tmp;
    endfunction

    // apply one accepted request and queue its result
    function void take_request(logic [spq_pkg::ActionW-1:0] act,
                               logic [spq_pkg::TagW-1:0] new_tag,
                               logic [spq_pkg::SevW-1:0] new_sev);
      reply_t      r;
      int unsigned pos;
      int unsigned up;
      int unsigned best;
      int unsigned kid;
      bit          settled;
      r.tag = '0;
      requests_taken++;
      case (act)
        spq_pkg::ACT_INSERT: begin
          if (held >= spq_pkg::Capacity) begin
            r.status = spq_pkg::ST_DROPPED;
          end else begin
            heap_mem[held] = {new_sev, arrival, new_tag};
            pos = held;
            held++;
            // sift up
            settled = 1'b0;
            while (!settled && pos > 0) begin
              up = (pos - 1) / 2;
              if (outranks(heap_mem[pos], heap_mem[up])) begin
                swap(pos, up);
                pos = up;
              end else begin
                settled = 1'b1;
              end
            end
            r.status = spq_pkg::ST_INSERTED;
          end
          arrival++;
        end
        spq_pkg::ACT_SERVE: begin
          if (held == 0) begin
            r.status = spq_pkg::ST_EMPTY;
          end else begin
            r.tag = heap_mem[0].tag;
            held--;
            if (held > 0) begin
              heap_mem[0] = heap_mem[held];
              // sift down
              pos     = 0;
              settled = 1'b0;
              while (!settled) begin
                best = pos;
                kid  = 2 * pos + 1;
                if (kid < held && outranks(heap_mem[kid], heap_mem[best])) best = kid;
                if (kid + 1 < held && outranks(heap_mem[kid + 1], heap_mem[best])) begin
                  best = kid + 1;
                end
                if (best == pos) begin
                  settled = 1'b1;
                end else begin
                  swap(pos, best);
                  pos = best;
                end
              end
            end
            r.status = spq_pkg::ST_SERVED;
          end
          arrival++;
        end
        default: begin
          held     = 0;
          arrival  = '0;
          r.status = spq_pkg::ST_CLEARED;
        end
      endcase
      r.occ = spq_pkg::OccW'(held);
      if (held > peak_held) peak_held = held;
      status_count[r.status]++;
      expected_replies.push_back(r);
    endfunction

    function void flag_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("mismatch: %s", msg);
    endfunction

    // compare one result transfer with the oldest prediction
    function void check_reply(logic [spq_pkg::StatusW-1:0] status,
                              logic [spq_pkg::TagW-1:0] tag,
                              logic [spq_pkg::OccW-1:0] occ);
      reply_t want;
      if (expected_replies.size() == 0) begin
        flag_mismatch($sformatf("unexpected result status %0d tag %h occupancy %0d",
                                status, tag, occ));
      end else begin
        want = expected_replies.pop_front();
        if (status !== want.status || tag !== want.tag || occ !== want.occ) begin
          flag_mismatch($sformatf(
            "expected status %0d tag %h occupancy %0d, got status %0d tag %h occupancy %0d",
            want.status, want.tag, want.occ, status, tag, occ));
        end
      end
    endfunction

    function int unsigned pending();
      return expected_replies.size();
    endfunction
  endclass

  logic                              clk_i;
  logic                              rst_ni        = 1'b0;
  logic                              in_valid_i    = 1'b0;
  logic                              in_ready_o;
  logic [spq_pkg::ActionW-1:0]       action_i      = spq_pkg::ACT_INSERT;
  logic [spq_pkg::TagW-1:0]          patient_tag_i = '0;
  logic signed [spq_pkg::SevW-1:0]   severity_i    = '0;
  logic                              out_valid_o;
  logic                              out_ready_i   = 1'b0;
  logic [spq_pkg::StatusW-1:0]       status_o;
  logic [spq_pkg::TagW-1:0]          served_tag_o;
  logic [spq_pkg::OccW-1:0]          occupancy_o;

  bit            send_gaps = 1'b1;
  bit            take_gaps = 1'b1;
  heap_predictor predictor;

  stable_priority_queue_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .patient_tag_i (patient_tag_i),
    .severity_i    (severity_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .served_tag_o  (served_tag_o),
    .occupancy_o   (occupancy_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watch both channels for transfers
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && in_ready_o) begin
      predictor.take_request(action_i, patient_tag_i, severity_i);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      predictor.check_reply(status_o, served_tag_o, occupancy_o);
    end
  end

  // receiver: random stall before each result
  initial begin
    int unsigned gap;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = take_gaps ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("testbench failed");
    $finish;
  end

  function automatic logic [spq_pkg::ActionW-1:0] pick_action(mix_e kind);
    int unsigned                 roll;
    logic [spq_pkg::ActionW-1:0] act;
    roll = $urandom_range(0, 99);
    case (kind)
      FILL_PHASE: begin
        act = (roll < 90) ? spq_pkg::ACT_INSERT : spq_pkg::ACT_SERVE;
      end
      DRAIN_PHASE: begin
        act = (roll < 25) ? spq_pkg::ACT_INSERT :
              (roll < 98) ? spq_pkg::ACT_SERVE : ACT_SPARE;
      end
      TIE_PHASE: begin
        act = (roll < 60) ? spq_pkg::ACT_INSERT :
              (roll < 97) ? spq_pkg::ACT_SERVE : spq_pkg::ACT_CLEAR;
      end
      default: begin
        act = (roll < 55) ? spq_pkg::ACT_INSERT : (roll < 92) ? spq_pkg::ACT_SERVE :
              (roll < 96) ? spq_pkg::ACT_CLEAR : ACT_SPARE;
      end
    endcase
    return act;
  endfunction

  // narrow draws force many equal severities
  function automatic logic [spq_pkg::SevW-1:0] draw_severity(bit narrow);
    int unsigned              roll;
    logic [spq_pkg::SevW-1:0] s;
    roll = $urandom_range(0, 9);
    if (narrow || roll < 3) begin
      s = spq_pkg::SevW'($urandom_range(0, 4) - 32'd2);
    end else if (roll == 3) begin
      s = 16'h8000;
    end else if (roll == 4) begin
      s = 16'h7fff;
    end else begin
      s = spq_pkg::SevW'($urandom);
    end
    return s;
  endfunction

  // present one request and hold it until the transfer
  task automatic send_request(logic [spq_pkg::ActionW-1:0] act,
                              logic [spq_pkg::TagW-1:0] tag,
                              logic [spq_pkg::SevW-1:0] sev);
    int unsigned gap;
    gap = send_gaps ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    action_i      <= act;
    patient_tag_i <= tag;
    severity_i    <= sev;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // hold off the sender until every result is back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (predictor.pending() != 0);
  endtask

  // main sequence
  initial begin
    mix_e kind;
    predictor = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: empty serve, extremes, ties, both clear codes
    send_request(spq_pkg::ACT_SERVE,  16'h0000, 16'h0000);
    send_request(spq_pkg::ACT_INSERT, 16'h0000, 16'h8000);
    send_request(spq_pkg::ACT_INSERT, 16'hffff, 16'h7fff);
    send_request(spq_pkg::ACT_INSERT, 16'h1234, 16'h0000);
    send_request(spq_pkg::ACT_INSERT, 16'h0001, 16'h0000);
    send_request(spq_pkg::ACT_INSERT, 16'h0002, 16'h0000);
    send_request(spq_pkg::ACT_INSERT, 16'haaaa, 16'hffff);
    send_request(spq_pkg::ACT_INSERT, 16'h5555, 16'h0001);
    repeat (8) send_request(spq_pkg::ACT_SERVE, 16'hffff, 16'hffff);
    send_request(spq_pkg::ACT_INSERT, 16'h00aa, 16'h0064);
    send_request(spq_pkg::ACT_CLEAR,  16'hffff, 16'h7fff);
    send_request(spq_pkg::ACT_INSERT, 16'h0bb0, 16'h0005);
    send_request(ACT_SPARE,           16'h0000, 16'h8000);
    send_request(spq_pkg::ACT_SERVE,  16'h0000, 16'h0000);
    wait_drained();

    // random phases, some without any idling
    for (int ph = 0; ph < PHASES; ph++) begin
      kind      = mix_e'(ph % 4);
      send_gaps = (ph % 3 != 2);
      take_gaps = (ph % 4 != 3);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_request(pick_action(kind), spq_pkg::TagW'($urandom),
                     draw_severity(kind == TIE_PHASE));
      end
      if (ph % 2 == 1) wait_drained();
    end

    wait_drained();
    repeat (SETTLE_TICKS) @(posedge clk_i);

    $display("covered %0d requests: %0d inserted, %0d served, %0d serves on an empty queue",
             predictor.requests_taken, predictor.status_count[spq_pkg::ST_INSERTED],
             predictor.status_count[spq_pkg::ST_SERVED],
             predictor.status_count[spq_pkg::ST_EMPTY]);
    $display("%0d inserts dropped when full, %0d clears, peak occupancy %0d, %0d mismatches",
             predictor.status_count[spq_pkg::ST_DROPPED],
             predictor.status_count[spq_pkg::ST_CLEARED],
             predictor.peak_held, predictor.mismatches);
    if (predictor.mismatches == 0 && predictor.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
